/* rtl/wlmu_pkg.sv */
package wlmu_pkg;

    localparam int PAGE_BYTES = 65536;
    localparam int MAX_PAGES  = 4;
    localparam int MEM_BYTES  = PAGE_BYTES * MAX_PAGES;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int ADDR_W     = $clog2(MEM_BYTES);
    localparam int LIM_W      = ADDR_W + 1;
    localparam int PAGE_W     = $clog2(MAX_PAGES + 1);
    localparam int DMAX_W     = 17;

    localparam logic [4:0] K_LOAD_FIRST  = 5'd0;
    localparam logic [4:0] K_LOAD_LAST   = 5'd13;
    localparam logic [4:0] K_STORE_FIRST = 5'd14;
    localparam logic [4:0] K_STORE_LAST  = 5'd22;
    localparam logic [4:0] K_SIZE        = 5'd23;
    localparam logic [4:0] K_GROW        = 5'd24;

    localparam logic [1:0] VT_I32 = 2'd0;
    localparam logic [1:0] VT_I64 = 2'd1;
    localparam logic [1:0] VT_F32 = 2'd2;
    localparam logic [1:0] VT_F64 = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OOB  = 2'd1;
    localparam logic [1:0] ST_TYPE = 2'd2;

    typedef struct packed {
        logic [4:0]         kind;
        logic [31:0]        address;
        logic [31:0]        offset;
        logic [63:0]        store_value;
        logic [1:0]         value_type;
        logic signed [31:0] grow_delta;
    } req_t;

    typedef struct packed {
        logic [63:0] result_value;
        logic [1:0]  status;
    } rsp_t;

    typedef struct packed {
        logic capture;
        logic setup;
        logic rd_en;
        logic wr_en;
        logic clr_en;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic go_load;
        logic go_store;
        logic go_clear;
        logic byte_last;
        logic clear_last;
    } stat_t;

    typedef struct packed {
        logic [3:0] size;
        logic       sext;
        logic       wide;
    } load_desc_t;

    typedef struct packed {
        logic [3:0] size;
        logic [1:0] tag;
    } store_desc_t;

    function automatic load_desc_t load_desc(input logic [4:0] kind);
        load_desc_t d;
        case (kind)
            5'd0:    d = '{4'd4, 1'b0, 1'b0};
            5'd1:    d = '{4'd8, 1'b0, 1'b1};
            5'd2:    d = '{4'd4, 1'b0, 1'b0};
            5'd3:    d = '{4'd8, 1'b0, 1'b1};
            5'd4:    d = '{4'd1, 1'b1, 1'b0};
            5'd5:    d = '{4'd1, 1'b0, 1'b0};
            5'd6:    d = '{4'd2, 1'b1, 1'b0};
            5'd7:    d = '{4'd2, 1'b0, 1'b0};
            5'd8:    d = '{4'd1, 1'b1, 1'b1};
            5'd9:    d = '{4'd1, 1'b0, 1'b1};
            5'd10:   d = '{4'd2, 1'b1, 1'b1};
            5'd11:   d = '{4'd2, 1'b0, 1'b1};
            5'd12:   d = '{4'd4, 1'b1, 1'b1};
            5'd13:   d = '{4'd4, 1'b0, 1'b1};
            default: d = '{4'd1, 1'b0, 1'b0};
        endcase
        return d;
    endfunction

    function automatic store_desc_t store_desc(input logic [4:0] kind);
        store_desc_t d;
        case (kind)
            5'd14:   d = '{4'd4, VT_I32};
            5'd15:   d = '{4'd8, VT_I64};
            5'd16:   d = '{4'd4, VT_F32};
            5'd17:   d = '{4'd8, VT_F64};
            5'd18:   d = '{4'd1, VT_I32};
            5'd19:   d = '{4'd2, VT_I32};
            5'd20:   d = '{4'd1, VT_I64};
            5'd21:   d = '{4'd2, VT_I64};
            5'd22:   d = '{4'd4, VT_I64};
            default: d = '{4'd1, VT_I32};
        endcase
        return d;
    endfunction

endpackage

/* rtl/wlmu_ctrl.sv */
module wlmu_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  wlmu_pkg::stat_t stat,
    output wlmu_pkg::cmd_t  cmd,
    output logic            busy,
    output logic            done
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_LOAD  = 7'b0000100,
        S_TAIL  = 7'b0001000,
        S_STORE = 7'b0010000,
        S_CLEAR = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.setup = 1'b1;
                if (stat.go_load)
                begin
                    state_next = S_LOAD;
                end
                else if (stat.go_store)
                begin
                    state_next = S_STORE;
                end
                else if (stat.go_clear)
                begin
                    state_next = S_CLEAR;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_LOAD:
            begin
                cmd.rd_en = 1'b1;
                if (stat.byte_last)
                begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                state_next = S_DONE;
            end
            S_STORE:
            begin
                cmd.wr_en = 1'b1;
                if (stat.byte_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                cmd.commit = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

/* rtl/wlmu_datapath.sv */
module wlmu_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  wlmu_pkg::req_t               req,
    input  wlmu_pkg::cmd_t               cmd,
    input  logic                         cfg_we,
    input  logic [wlmu_pkg::DMAX_W-1:0]  cfg_data,
    output wlmu_pkg::stat_t              stat,
    output wlmu_pkg::rsp_t               rsp
);

    logic [7:0] mem [wlmu_pkg::MEM_BYTES];

    wlmu_pkg::req_t                req_reg;
    logic [wlmu_pkg::DMAX_W-1:0]   dmax_reg;
    logic [wlmu_pkg::PAGE_W-1:0]   pc_reg;
    logic [2:0]                    cnt_reg;
    logic [wlmu_pkg::ADDR_W-1:0]   clr_reg;
    logic [63:0]                   acc_reg;
    logic [7:0]                    memq_reg;
    logic                          pend_reg;
    logic [2:0]                    pidx_reg;

    wlmu_pkg::load_desc_t          ld;
    wlmu_pkg::store_desc_t         sd;
    logic                          is_load;
    logic                          is_store;
    logic                          is_size;
    logic                          is_grow;
    logic [32:0]                   ea;
    logic [33:0]                   ea_end;
    logic [wlmu_pkg::LIM_W-1:0]    limit;
    logic [3:0]                    acc_size;
    logic                          oob;
    logic                          store_type_ok;
    logic signed [33:0]            n_pages;
    logic                          grow_fail;
    logic                          grow_ok;
    logic [wlmu_pkg::PAGE_W-1:0]   new_pc;
    logic [wlmu_pkg::LIM_W-1:0]    new_end;
    logic [wlmu_pkg::ADDR_W-1:0]   addr;
    logic [63:0]                   load_val;
    logic [1:0]                    status;

    always_comb
    begin
        ld       = wlmu_pkg::load_desc(req_reg.kind);
        sd       = wlmu_pkg::store_desc(req_reg.kind);
        is_load  = req_reg.kind inside {[wlmu_pkg::K_LOAD_FIRST:wlmu_pkg::K_LOAD_LAST]};
        is_store = req_reg.kind inside {[wlmu_pkg::K_STORE_FIRST:wlmu_pkg::K_STORE_LAST]};
        is_size  = (req_reg.kind == wlmu_pkg::K_SIZE);
        is_grow  = (req_reg.kind == wlmu_pkg::K_GROW);
        acc_size = is_load ? ld.size : sd.size;
        ea       = {1'b0, req_reg.address} + {1'b0, req_reg.offset};
        ea_end   = {1'b0, ea} + 34'(acc_size);
        limit    = wlmu_pkg::LIM_W'(pc_reg) << wlmu_pkg::PAGE_SHIFT;
        oob      = (ea_end > 34'(limit));
        store_type_ok = (req_reg.value_type == sd.tag);
    end

    // grow: signed page sum, no wrap
    always_comb
    begin
        n_pages   = $signed({{(34 - wlmu_pkg::PAGE_W){1'b0}}, pc_reg})
                  + $signed({{2{req_reg.grow_delta[31]}}, req_reg.grow_delta});
        grow_fail = !n_pages[33]
                    && ((n_pages[32:0] > 33'(wlmu_pkg::MAX_PAGES))
                        || ((dmax_reg != '0) && (n_pages[32:0] > 33'(dmax_reg))));
        grow_ok   = is_grow && (req_reg.value_type == wlmu_pkg::VT_I32) && !grow_fail;
        new_pc    = (n_pages[33] || (n_pages == '0)) ? '0 : n_pages[wlmu_pkg::PAGE_W-1:0];
        new_end   = wlmu_pkg::LIM_W'(new_pc) << wlmu_pkg::PAGE_SHIFT;
    end

    always_comb
    begin
        stat.go_load    = is_load && !oob;
        stat.go_store   = is_store && store_type_ok && !oob;
        stat.go_clear   = grow_ok && (new_pc > pc_reg);
        stat.byte_last  = ({1'b0, cnt_reg} == (acc_size - 4'd1));
        stat.clear_last = (({1'b0, clr_reg} + 1'b1) == new_end);
    end

    assign addr = cmd.clr_en ? clr_reg : (ea[wlmu_pkg::ADDR_W-1:0] + wlmu_pkg::ADDR_W'(cnt_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[addr] <= req_reg.store_value[cnt_reg*8 +: 8];
        end
        else if (cmd.clr_en)
        begin
            mem[addr] <= 8'h00;
        end
        memq_reg <= mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dmax_reg <= '0;
            pc_reg   <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                dmax_reg <= cfg_data;
            end
            if (cmd.commit && grow_ok)
            begin
                pc_reg <= new_pc;
            end
            pend_reg <= cmd.rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req;
            acc_reg <= '0;
        end
        if (cmd.setup)
        begin
            cnt_reg <= '0;
            clr_reg <= limit[wlmu_pkg::ADDR_W-1:0];
        end
        if (cmd.rd_en || cmd.wr_en)
        begin
            cnt_reg <= cnt_reg + 3'd1;
        end
        if (cmd.clr_en)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
        pidx_reg <= cnt_reg;
        if (pend_reg)
        begin
            acc_reg[pidx_reg*8 +: 8] <= memq_reg;
        end
    end

    always_comb
    begin
        case (ld.size)
            4'd1:    load_val = {{56{ld.sext & acc_reg[7]}}, acc_reg[7:0]};
            4'd2:    load_val = {{48{ld.sext & acc_reg[15]}}, acc_reg[15:0]};
            4'd4:    load_val = {{32{ld.sext & acc_reg[31]}}, acc_reg[31:0]};
            default: load_val = acc_reg;
        endcase
        if (!ld.wide)
        begin
            load_val[63:32] = '0;
        end
    end

    always_comb
    begin
        status           = wlmu_pkg::ST_OK;
        rsp.result_value = '0;
        if (is_load)
        begin
            if (oob)
            begin
                status = wlmu_pkg::ST_OOB;
            end
            else
            begin
                rsp.result_value = load_val;
            end
        end
        else if (is_store)
        begin
            if (!store_type_ok)
            begin
                status = wlmu_pkg::ST_TYPE;
            end
            else if (oob)
            begin
                status = wlmu_pkg::ST_OOB;
            end
        end
        else if (is_size)
        begin
            rsp.result_value = 64'(pc_reg);
        end
        else if (is_grow)
        begin
            if (req_reg.value_type != wlmu_pkg::VT_I32)
            begin
                status = wlmu_pkg::ST_TYPE;
            end
            else if (grow_fail)
            begin
                rsp.result_value = 64'h0000_0000_FFFF_FFFF;
            end
            else
            begin
                rsp.result_value = 64'(pc_reg);
            end
        end
        rsp.status = status;
    end

endmodule

/* rtl/wasm_linear_memory_unit.sv */
// steps: load walks its bytes then a tail step, store walks its bytes; size query and
// failed or trapped access report at once; grow clears each new byte (up to 262144)
// throughput: one item at a time through the single byte-wide memory port; busy high
// while working, next start taken the cycle after done; result shown for one cycle
// with done; the receiver cannot stall
// reset: page count and declared maximum cleared; memory is not swept, each grow
// clears the pages it opens
module wasm_linear_memory_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  wlmu_pkg::req_t               req,
    output logic                         done,
    output wlmu_pkg::rsp_t               rsp,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [wlmu_pkg::DMAX_W-1:0]  cfg_data
);

    wlmu_pkg::cmd_t  cmd;
    wlmu_pkg::stat_t stat;

    // config beat always taken; writes must come only while idle, the block does not enforce it
    assign cfg_ready = 1'b1;

    // sequencer: capture, check, byte loop or page clear, then report
    wlmu_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // request register, bounds and grow arithmetic, byte memory
    wlmu_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cmd      (cmd),
        .cfg_we   (cfg_valid & cfg_ready),
        .cfg_data (cfg_data),
        .stat     (stat),
        .rsp      (rsp)
    );

endmodule
